// ===== rtl/ddd_pkg.sv =====
package ddd_pkg;

    // Field widths of the date and count beats
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);

    // floor(y / 100) = (y * RECIP100) >> RECIP_SHIFT, exact for any 15-bit y
    localparam int                RECIP_W     = 16;
    localparam int                RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP100   = RECIP_W'(41944);
    localparam logic [RECIP_W-1:0] DAYS_YEAR  = RECIP_W'(365);
    localparam int                PROD_W      = YEAR_W + RECIP_W;
    localparam int                Q_W         = PROD_W - RECIP_SHIFT;

    // 365 * year fits here; signed accumulator with headroom for the difference
    localparam int DAYS_W = 23;
    localparam int ACC_W  = 26;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Month length, 0 for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            MONTH_FEB:                                  len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/ddd_if.sv =====
// Date pair beat into the block
interface ddd_in_if;
    import ddd_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;

    modport source (
        output valid, start_year, start_month, start_day, end_year, end_month, end_day,
        input  ready
    );

    modport sink (
        input  valid, start_year, start_month, start_day, end_year, end_month, end_day,
        output ready
    );
endinterface

// Day count beat out of the block
interface ddd_out_if;
    import ddd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] day_count;

    modport source (
        output valid, day_count,
        input  ready
    );

    modport sink (
        input  valid, day_count,
        output ready
    );
endinterface

// ===== rtl/date_difference_in_days.sv =====
// Day count between two Gregorian dates. Each input beat carries two dates in
// either order; the block orders them (year, then raw month, then raw day),
// then accumulates 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400) + day-of-year
// for the later date and subtracts the same for the earlier one, all through
// one shared multiplier and one accumulator adder under a small sequencer. A
// month or day out of range gives that date day-of-year 0; years above
// MAX_YEAR are clamped. include_end_day (cfg_wr_en/cfg_wr_data) adds one day.
// Each date runs S_RECIP, S_SCALE, S_LEAPS, S_YEARS, an S_MONTH step for
// each month up to its own month (none if the date is invalid) and S_NEXT;
// S_DONE then loads the output register. in_ch.ready is low while a beat
// is in work. The result sits in an output register, so the block takes the
// next beat while a result still waits to be taken. Negative counts read 0,
// counts above 2^22-1 saturate.
module date_difference_in_days #(
    parameter int unsigned MAX_YEAR = ddd_pkg::MAX_YEAR_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    ddd_in_if.sink    in_ch,
    ddd_out_if.source out_ch
);
    import ddd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_SCALE,
        S_LEAPS,
        S_YEARS,
        S_MONTH,
        S_NEXT,
        S_DONE
    } state_t;

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        r = y;
        if (32'(y) > MAX_YEAR)
            r = YEAR_W'(MAX_YEAR);
        return r;
    endfunction

    // Control registers
    state_t             state_reg, state_next;
    logic               side_reg, side_next;      // 0: later date (add), 1: earlier (subtract)
    logic [MONTH_W-1:0] mcnt_reg, mcnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               incl_reg, incl_next;

    // Datapath registers
    logic [YEAR_W-1:0]  ey_reg, ey_next, ly_reg, ly_next;
    logic [MONTH_W-1:0] em_reg, em_next, lm_reg, lm_next;
    logic [DAY_W-1:0]   ed_reg, ed_next, ld_reg, ld_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic               leap_reg, leap_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic               in_fire;
    logic [YEAR_W-1:0]  ay, by;
    logic               a_first;
    logic [YEAR_W-1:0]  cur_y;
    logic [MONTH_W-1:0] cur_m;
    logic [DAY_W-1:0]   cur_d;
    logic [RECIP_W-1:0] mul_k;
    logic [PROD_W-1:0]  mul_p;
    logic [YEAR_W:0]    q_ext, hund, c4, c100, c400, leap_term;
    logic               div100, leap_now;
    logic [DAY_W-1:0]   mlen_cur, mlen_walk;
    logic               date_ok;
    logic [ACC_W-1:0]   opnd, acc_sum;
    logic [COUNT_W-1:0] sat_count;

    assign in_fire = in_ch.valid && in_ch.ready;

    // Order the two dates
    assign ay      = clamp_year(in_ch.start_year);
    assign by      = clamp_year(in_ch.end_year);
    assign a_first = (ay < by) ||
                     (ay == by && (in_ch.start_month < in_ch.end_month ||
                      (in_ch.start_month == in_ch.end_month &&
                       in_ch.start_day < in_ch.end_day)));

    // Date under work
    assign cur_y = side_reg ? ey_reg : ly_reg;
    assign cur_m = side_reg ? em_reg : lm_reg;
    assign cur_d = side_reg ? ed_reg : ld_reg;

    // Shared multiplier: y * reciprocal of 100, then y * 365
    assign mul_k = (state_reg == S_RECIP) ? RECIP100 : DAYS_YEAR;
    assign mul_p = PROD_W'(cur_y) * PROD_W'(mul_k);

    // Leap-day count and leap flag from q = floor(y / 100)
    assign q_ext     = (YEAR_W + 1)'(q_reg);
    assign hund      = (q_ext << 6) + (q_ext << 5) + (q_ext << 2);
    assign div100    = (hund == (YEAR_W + 1)'(cur_y));
    assign c4        = ((YEAR_W + 1)'(cur_y) + (YEAR_W + 1)'(3)) >> 2;
    assign c100      = q_ext + (YEAR_W + 1)'(!div100);
    assign c400      = (c100 + (YEAR_W + 1)'(3)) >> 2;
    assign leap_term = c4 - c100 + c400;
    assign leap_now  = (cur_y[1:0] == 2'b00) && (!div100 || q_reg[1:0] == 2'b00);

    // Date check and month walk table
    assign mlen_cur  = month_len(cur_m, leap_reg);
    assign mlen_walk = month_len(mcnt_reg, leap_reg);
    assign date_ok   = (cur_m >= MONTH_FIRST) && (cur_m <= MONTH_LAST) &&
                       (cur_d != '0) && (cur_d <= mlen_cur);

    // Shared accumulator adder
    always_comb
    begin
        case (state_reg)
            S_LEAPS: opnd = ACC_W'(leap_term);
            S_YEARS: opnd = ACC_W'(prod_reg[DAYS_W-1:0]);
            S_MONTH: opnd = (mcnt_reg == cur_m) ? ACC_W'(cur_d) : ACC_W'(mlen_walk);
            default: opnd = '0;
        endcase
    end

    assign acc_sum = side_reg ? (acc_reg - opnd) : (acc_reg + opnd);

    // Clamp to 0 .. 2^22-1
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            sat_count = '0;
        else if (acc_reg[ACC_W-2:COUNT_W] != '0)
            sat_count = COUNT_MAX;
        else
            sat_count = acc_reg[COUNT_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        count_next     = count_reg;
        incl_next      = cfg_wr_en ? cfg_wr_data : incl_reg;
        ey_next        = ey_reg;
        em_next        = em_reg;
        ed_next        = ed_reg;
        ly_next        = ly_reg;
        lm_next        = lm_reg;
        ld_next        = ld_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        leap_next      = leap_reg;
        acc_next       = acc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (a_first)
                    begin
                        ey_next = ay;  em_next = in_ch.start_month;  ed_next = in_ch.start_day;
                        ly_next = by;  lm_next = in_ch.end_month;    ld_next = in_ch.end_day;
                    end
                    else
                    begin
                        ey_next = by;  em_next = in_ch.end_month;    ed_next = in_ch.end_day;
                        ly_next = ay;  lm_next = in_ch.start_month;  ld_next = in_ch.start_day;
                    end
                    acc_next   = ACC_W'(incl_reg);
                    side_next  = 1'b0;
                    state_next = S_RECIP;
                end
            end
            S_RECIP:
            begin
                prod_next  = mul_p;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                q_next     = prod_reg[RECIP_SHIFT +: Q_W];
                prod_next  = mul_p;
                state_next = S_LEAPS;
            end
            S_LEAPS:
            begin
                leap_next  = leap_now;
                acc_next   = acc_sum;
                state_next = S_YEARS;
            end
            S_YEARS:
            begin
                acc_next   = acc_sum;
                mcnt_next  = MONTH_FIRST;
                state_next = date_ok ? S_MONTH : S_NEXT;
            end
            S_MONTH:
            begin
                acc_next = acc_sum;
                if (mcnt_reg == cur_m)
                    state_next = S_NEXT;
                else
                    mcnt_next = mcnt_reg + MONTH_W'(1);
            end
            S_NEXT:
            begin
                if (side_reg)
                    state_next = S_DONE;
                else
                begin
                    side_next  = 1'b1;
                    state_next = S_RECIP;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = sat_count;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            incl_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            incl_reg      <= incl_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        ey_reg   <= ey_next;
        em_reg   <= em_next;
        ed_reg   <= ed_next;
        ly_reg   <= ly_next;
        lm_reg   <= lm_next;
        ld_reg   <= ld_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        leap_reg <= leap_next;
        acc_reg  <= acc_next;
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.day_count = count_reg;

`ifndef SYNTHESIS
    // No second beat while one is in work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("input accepted while a beat is in work");

    // Dates stay ordered by year during the walk
    a_years_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (ey_reg <= ly_reg))
        else $error("earlier date has the larger year");

    // Month walk stays inside a valid month
    a_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (mcnt_reg >= MONTH_FIRST && mcnt_reg <= cur_m &&
                                    cur_m <= MONTH_LAST))
        else $error("month walk out of range");

    // A result appears only at the end of a walk
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finish step");
`endif

endmodule

// ===== sim/date_difference_in_days_tb.sv =====
module date_difference_in_days_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddd_pkg::*;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PAIRS_PER_PHASE = 275;
    localparam int TAIL_CYCLES     = 50;

    // One input beat: two dates in either order
    typedef struct {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } date_pair_t;

    // Day count predictor plus the queue of counts still owed by the block
    class DayCountBoard;
        logic [COUNT_W-1:0] expected_counts[$];
        bit                 include_end_day;
        int                 fail_count;

        function new();
            include_end_day = 1'b0;
            fail_count      = 0;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH: %s", what);
            fail_count++;
        endtask

        function bit is_leap(input longint y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        function int month_days(input longint m, input bit leap_year);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // Days in years 0 .. y-1
        function longint days_before_year(input longint y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        // Out-of-range month or day gives 0
        function longint day_of_year(input longint y, input longint m, input longint d);
            longint total;
            bit     lp;
            total = 0;
            lp    = is_leap(y);
            if (m < 1 || m > 12)
                return 0;
            if (d < 1 || d > month_days(m, lp))
                return 0;
            for (int i = 1; i < m; i++)
                total += month_days(i, lp);
            return total + d;
        endfunction

        function logic [COUNT_W-1:0] predict_count(input date_pair_t p);
            longint sy, sm, sd, ey, em, ed;
            longint fy, fm, fd, ly, lm, ld;
            longint total;
            bit     start_first;
            sy = (p.start_year > MAX_YEAR_DEF) ? MAX_YEAR_DEF : p.start_year;
            ey = (p.end_year > MAX_YEAR_DEF) ? MAX_YEAR_DEF : p.end_year;
            sm = p.start_month;
            sd = p.start_day;
            em = p.end_month;
            ed = p.end_day;
            // ordering uses raw month and day
            start_first = (sy < ey) || (sy == ey && (sm < em || (sm == em && sd < ed)));
            if (start_first)
            begin
                fy = sy; fm = sm; fd = sd; ly = ey; lm = em; ld = ed;
            end
            else
            begin
                fy = ey; fm = em; fd = ed; ly = sy; lm = sm; ld = sd;
            end
            total = days_before_year(ly) - days_before_year(fy)
                  + day_of_year(ly, lm, ld) - day_of_year(fy, fm, fd)
                  + longint'(include_end_day);
            if (total < 0)
                total = 0;
            if (total > longint'(COUNT_MAX))
                total = longint'(COUNT_MAX);
            return COUNT_W'(total);
        endfunction

        function void note_pair(input date_pair_t p);
            expected_counts.push_back(predict_count(p));
        endfunction

        task check_count(input logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("day_count %0d with no beat pending", got));
            end
            else
            begin
                want = expected_counts.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("day_count got %0d want %0d", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ddd_in_if  in_ch();
    ddd_out_if out_ch();

    DayCountBoard board;
    bit           no_idle = 1'b0;
    int           cycle_count = 0;
    int           stall_left = 0;

    date_difference_in_days dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            stall_left = pick_gap();
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result beats
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_count(out_ch.day_count);
    end

    function automatic date_pair_t make_pair(input int sy, input int sm, input int sd,
                                             input int ey, input int em, input int ed);
        date_pair_t p;
        p.start_year  = YEAR_W'(sy);
        p.start_month = MONTH_W'(sm);
        p.start_day   = DAY_W'(sd);
        p.end_year    = YEAR_W'(ey);
        p.end_month   = MONTH_W'(em);
        p.end_day     = DAY_W'(ed);
        return p;
    endfunction

    // Years that stress the 4/100/400 rule
    function automatic int pick_year();
        int special_years[12] = '{1, 4, 100, 400, 1600, 1700, 1900, 2000, 2100,
                                  2400, 9996, 9999};
        if ($urandom_range(0, 3) == 0)
            return special_years[$urandom_range(0, 11)];
        return $urandom_range(1, MAX_YEAR_DEF);
    endfunction

    // Valid month and day for a year, month end picked often
    task automatic valid_day(input int y, output int m, output int d);
        int len;
        bit lp;
        lp  = board.is_leap(y);
        m   = $urandom_range(1, 12);
        len = board.month_days(m, lp);
        d   = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    endtask

    task automatic random_pair(output date_pair_t p);
        int sy, sm, sd, ey, em, ed;
        int r;
        if ($urandom_range(0, 99) < 85)
        begin
            // well-formed dates
            sy = pick_year();
            r  = $urandom_range(0, 9);
            if (r < 6)
                ey = pick_year();
            else if (r < 9)
                ey = (sy + $urandom_range(0, 3) > MAX_YEAR_DEF) ? MAX_YEAR_DEF
                                                                : sy + $urandom_range(0, 3);
            else
                ey = sy;
            valid_day(sy, sm, sd);
            valid_day(ey, em, ed);
            p = make_pair(sy, sm, sd, ey, em, ed);
        end
        else
        begin
            // raw noise, sometimes within one year
            p.start_year  = YEAR_W'($urandom);
            p.start_month = MONTH_W'($urandom);
            p.start_day   = DAY_W'($urandom);
            p.end_year    = YEAR_W'($urandom);
            p.end_month   = MONTH_W'($urandom);
            p.end_day     = DAY_W'($urandom);
            if ($urandom_range(0, 2) == 0)
                p.end_year = p.start_year;
        end
    endtask

    task automatic send_pair(input date_pair_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.start_year  <= p.start_year;
        in_ch.start_month <= p.start_month;
        in_ch.start_day   <= p.start_day;
        in_ch.end_year    <= p.end_year;
        in_ch.end_month   <= p.end_month;
        in_ch.end_day     <= p.end_day;
        do @(posedge clk); while (!in_ch.ready);
        board.note_pair(p);
    endtask

    // Drop valid and let every pending count drain
    task automatic drain_counts(input int extra);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.expected_counts.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_cfg(input bit value);
        drain_counts(3);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        board.include_end_day = value;
    endtask

    initial
    begin
        date_pair_t directed[$];
        date_pair_t p;
        bit         cfg_plan[RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        board             = new();
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.start_year  = '0;
        in_ch.start_month = '0;
        in_ch.start_day   = '0;
        in_ch.end_year    = '0;
        in_ch.end_month   = '0;
        in_ch.end_day     = '0;
        out_ch.ready      = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners, end day excluded (reset value)
        directed.push_back(make_pair(1, 1, 1, 1, 1, 1));             // same date
        directed.push_back(make_pair(1, 1, 1, 9999, 12, 31));        // full range
        directed.push_back(make_pair(9999, 12, 31, 1, 1, 1));        // swapped order
        directed.push_back(make_pair(2000, 2, 29, 2000, 3, 1));      // leap century
        directed.push_back(make_pair(1900, 2, 29, 1900, 3, 1));      // Feb 29, non-leap
        directed.push_back(make_pair(2023, 2, 28, 2024, 2, 29));
        directed.push_back(make_pair(0, 1, 1, 1, 1, 1));             // year zero
        directed.push_back(make_pair(0, 2, 29, 0, 3, 1));            // year zero is leap
        directed.push_back(make_pair(16383, 15, 31, 1, 0, 0));       // clamp, raw maxima
        directed.push_back(make_pair(10000, 1, 1, 9999, 1, 1));      // clamp to equal years
        directed.push_back(make_pair(2020, 0, 5, 2020, 6, 15));      // month zero
        directed.push_back(make_pair(2020, 13, 1, 2021, 1, 1));      // month above 12
        directed.push_back(make_pair(2020, 7, 0, 2020, 5, 10));      // negative, clips to 0
        directed.push_back(make_pair(2020, 4, 31, 2020, 12, 31));    // day past month end
        directed.push_back(make_pair(2020, 12, 31, 2021, 1, 1));
        directed.push_back(make_pair(2019, 1, 31, 2019, 12, 31));
        directed.push_back(make_pair(100, 3, 1, 400, 3, 1));
        directed.push_back(make_pair(1, 1, 1, 1, 1, 2));
        directed.push_back(make_pair(5000, 6, 15, 5000, 6, 15));
        directed.push_back(make_pair(2020, 6, 30, 2020, 6, 31));     // invalid later day
        directed.push_back(make_pair(12345, 15, 0, 9999, 15, 31));
        foreach (directed[i])
            send_pair(directed[i]);

        // Random phases across both register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_cfg(cfg_plan[ph]);
            no_idle = (ph == 3);
            for (int i = 0; i < PAIRS_PER_PHASE; i++)
            begin
                random_pair(p);
                send_pair(p);
            end
        end
        no_idle = 1'b0;

        drain_counts(TAIL_CYCLES);
        if (board.expected_counts.size() != 0)
            board.report_mismatch($sformatf("%0d day counts never arrived",
                                            board.expected_counts.size()));

        if (board.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
